[rtl/scbp_pkg.sv]
`default_nettype none

package scbp_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int CLASS_DEPTH = 64;
    localparam int HANDLE_BITS = 48;

    // field widths
    localparam int SIZE_W   = 25;
    localparam int HANDLE_W = 48;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 33;
    localparam int SHIFT_W  = 5;
    localparam int MAXB_W   = 32;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 112;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int SHIFT_LIMIT = 24;

    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W   = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int STORED_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SHIFT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SHIFT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BYTES = 2'd2;

    localparam logic [SHIFT_W-1:0] MIN_SHIFT_RST = 5'd5;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT_RST = 5'd10;
    localparam logic [MAXB_W-1:0]  MAX_BYTES_RST = MAXB_W'(1024 * 1024);

    // operations
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TAKEN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_POOLED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN    = 3'd7;

    typedef struct packed {
        logic                pop;
        logic                push;
        logic [CLS_W-1:0]    cls;
        logic [STORED_W-1:0] handle;
    } t_store_req;

    // smallest s with 2^s >= size, for nonzero size
    function automatic logic [SHIFT_W-1:0] ceil_log2(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0]  v;
        logic [SHIFT_W-1:0] r;
        v = size - SIZE_W'(1);
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = SHIFT_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/scbp_free_store.sv]
`default_nettype none

module scbp_free_store (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire scbp_pkg::t_store_req           i_req,
    output logic [scbp_pkg::CNT_W-1:0]          o_count,
    output logic [scbp_pkg::STORED_W-1:0]       o_rd_handle
);

    logic [scbp_pkg::PTR_W-1:0]    r_head  [scbp_pkg::NUM_CLASSES];
    logic [scbp_pkg::PTR_W-1:0]    r_tail  [scbp_pkg::NUM_CLASSES];
    logic [scbp_pkg::CNT_W-1:0]    r_count [scbp_pkg::NUM_CLASSES];
    logic [scbp_pkg::STORED_W-1:0] mem     [scbp_pkg::MEM_DEPTH];
    logic [scbp_pkg::STORED_W-1:0] r_rd_handle;

    logic [scbp_pkg::PTR_W-1:0]  head_c;
    logic [scbp_pkg::PTR_W-1:0]  tail_c;
    logic [scbp_pkg::PTR_W-1:0]  ptr;
    logic [scbp_pkg::ADDR_W-1:0] addr;
    logic [scbp_pkg::PTR_W-1:0]  n_head;
    logic [scbp_pkg::PTR_W-1:0]  n_tail;

    assign head_c  = r_head[i_req.cls];
    assign tail_c  = r_tail[i_req.cls];
    assign o_count = r_count[i_req.cls];

    // a push writes at the tail, a pop reads at the head
    assign ptr  = i_req.push ? tail_c : head_c;
    assign addr = scbp_pkg::ADDR_W'(i_req.cls) * scbp_pkg::ADDR_W'(scbp_pkg::CLASS_DEPTH)
                + scbp_pkg::ADDR_W'(ptr);

    assign n_head = (head_c == scbp_pkg::PTR_W'(scbp_pkg::CLASS_DEPTH - 1)) ?
                    '0 : head_c + scbp_pkg::PTR_W'(1);
    assign n_tail = (tail_c == scbp_pkg::PTR_W'(scbp_pkg::CLASS_DEPTH - 1)) ?
                    '0 : tail_c + scbp_pkg::PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scbp_pkg::NUM_CLASSES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_req.pop) begin
            r_head[i_req.cls]  <= n_head;
            r_count[i_req.cls] <= o_count - scbp_pkg::CNT_W'(1);
        end else if (i_req.push) begin
            r_tail[i_req.cls]  <= n_tail;
            r_count[i_req.cls] <= o_count + scbp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[addr] <= i_req.handle;
        end
        if (i_req.pop) begin
            r_rd_handle <= mem[addr];
        end
    end

    assign o_rd_handle = r_rd_handle;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> o_count < scbp_pkg::CNT_W'(scbp_pkg::CLASS_DEPTH))
        else $error("push into a full class queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> o_count != '0)
        else $error("pop from an empty class queue");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.pop && i_req.push))
        else $error("pop and push in the same cycle");

endmodule

`default_nettype wire

[rtl/size_class_buffer_pool_unit.sv]
`default_nettype none

// Buffer pool with one free-handle queue per power-of-two size class. Takes one request
// per cycle (tuser 0 allocate, 1 release) and returns exactly one registered result per
// request; a waiting result does not stop the next request as long as the result is taken
// in the same cycle. The figure of one request per cycle is set by the single-port handle
// memory, which sees one read or one write per request, and by the class pointers and
// held-byte count that each request updates before the next.
// Allocate rounds the size up to a power of two and pops the oldest handle of that class;
// release pushes the handle unless the length is out of range, not a power of two, the
// pool already holds max_bytes or more, or the class queue is full. Configuration writes
// take effect at once and should only be made while no result is pending.
module size_class_buffer_pool_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [scbp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [scbp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // requests
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // request_size[24:0], buffer_handle[72:25], buffer_len[97:73], zero fill
    input  wire logic [scbp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation[0]
    input  wire logic                               s_axis_tuser,
    // results
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // granted_handle[47:0], granted_len[72:48], held_bytes[105:73], zero fill
    output logic [scbp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // status[2:0]
    output logic [scbp_pkg::STATUS_W-1:0]           m_axis_tuser
);

    logic [scbp_pkg::SHIFT_W-1:0] r_min_shift;
    logic [scbp_pkg::SHIFT_W-1:0] r_max_shift;
    logic [scbp_pkg::MAXB_W-1:0]  r_max_bytes;
    logic [scbp_pkg::HELD_W-1:0]  r_pool;
    logic                         r_valid;
    logic [scbp_pkg::STATUS_W-1:0] r_status;
    logic [scbp_pkg::SIZE_W-1:0]  r_glen;
    logic [scbp_pkg::HELD_W-1:0]  r_held;

    logic [scbp_pkg::STATUS_W-1:0] n_status;
    logic [scbp_pkg::SIZE_W-1:0]  n_glen;
    logic [scbp_pkg::HELD_W-1:0]  n_pool;

    logic                         s_acc;
    logic                         op;
    logic [scbp_pkg::SIZE_W-1:0]  req_size;
    logic [scbp_pkg::HANDLE_W-1:0] buf_handle;
    logic [scbp_pkg::SIZE_W-1:0]  buf_len;

    logic [scbp_pkg::SHIFT_W-1:0] lo;
    logic [scbp_pkg::SHIFT_W-1:0] max_sat;
    logic [scbp_pkg::SHIFT_W:0]   lo_span;
    logic [scbp_pkg::SHIFT_W-1:0] hi;
    logic                         any_class;
    logic [scbp_pkg::SHIFT_W-1:0] s_size;
    logic [scbp_pkg::SHIFT_W-1:0] s_len;
    logic [scbp_pkg::SHIFT_W-1:0] cls_shift;
    logic [scbp_pkg::SIZE_W-1:0]  pow_lo;
    logic [scbp_pkg::SIZE_W-1:0]  pow_hi;
    logic                         len_pow2;
    logic                         over_limit;
    logic                         do_pop;
    logic                         do_push;

    scbp_pkg::t_store_req          store_req;
    logic [scbp_pkg::CNT_W-1:0]    cls_count;
    logic [scbp_pkg::STORED_W-1:0] rd_handle;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign op         = s_axis_tuser;
    assign req_size   = s_axis_tdata[24:0];
    assign buf_handle = s_axis_tdata[72:25];
    assign buf_len    = s_axis_tdata[97:73];

    // effective class bounds, shifts saturated and span limited to the class count
    assign lo      = (r_min_shift > scbp_pkg::SHIFT_W'(scbp_pkg::SHIFT_LIMIT)) ?
                     scbp_pkg::SHIFT_W'(scbp_pkg::SHIFT_LIMIT) : r_min_shift;
    assign max_sat = (r_max_shift > scbp_pkg::SHIFT_W'(scbp_pkg::SHIFT_LIMIT)) ?
                     scbp_pkg::SHIFT_W'(scbp_pkg::SHIFT_LIMIT) : r_max_shift;
    assign lo_span = {1'b0, lo} + (scbp_pkg::SHIFT_W + 1)'(scbp_pkg::NUM_CLASSES - 1);
    assign hi      = ({1'b0, max_sat} > lo_span) ? lo_span[scbp_pkg::SHIFT_W-1:0] : max_sat;
    assign any_class = lo <= hi;

    assign s_size    = scbp_pkg::ceil_log2(req_size);
    assign s_len     = scbp_pkg::ceil_log2(buf_len);
    assign cls_shift = (op == scbp_pkg::OP_RELEASE) ? s_len : s_size;

    assign pow_lo     = scbp_pkg::SIZE_W'(1) << lo;
    assign pow_hi     = scbp_pkg::SIZE_W'(1) << hi;
    assign len_pow2   = (buf_len & (buf_len - scbp_pkg::SIZE_W'(1))) == '0;
    assign over_limit = r_pool >= {1'b0, r_max_bytes};

    always_comb begin
        n_status = scbp_pkg::ST_ZERO_SIZE;
        n_glen   = '0;
        n_pool   = r_pool;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        case (op)
            scbp_pkg::OP_ALLOC: begin
                if (req_size != '0) begin
                    if (s_size <= scbp_pkg::SHIFT_W'(scbp_pkg::SHIFT_LIMIT)) begin
                        n_glen = scbp_pkg::SIZE_W'(1) << s_size;
                    end
                    if (!any_class || s_size < lo || s_size > hi) begin
                        n_status = scbp_pkg::ST_OUT_RANGE;
                    end else if (cls_count == '0) begin
                        n_status = scbp_pkg::ST_EMPTY;
                    end else begin
                        n_status = scbp_pkg::ST_TAKEN;
                        do_pop   = 1'b1;
                        // clamp at zero if the config changed under held handles
                        n_pool   = (r_pool >= scbp_pkg::HELD_W'(n_glen)) ?
                                   r_pool - scbp_pkg::HELD_W'(n_glen) : '0;
                    end
                end
            end
            scbp_pkg::OP_RELEASE: begin
                if (!any_class || buf_len < pow_lo || buf_len > pow_hi) begin
                    n_status = scbp_pkg::ST_OUT_RANGE;
                end else if (!len_pow2) begin
                    n_status = scbp_pkg::ST_BAD_LEN;
                end else if (over_limit) begin
                    n_status = scbp_pkg::ST_OVER_LIMIT;
                end else if (cls_count >= scbp_pkg::CNT_W'(scbp_pkg::CLASS_DEPTH)) begin
                    n_status = scbp_pkg::ST_FULL;
                end else begin
                    n_status = scbp_pkg::ST_POOLED;
                    do_push  = 1'b1;
                    n_pool   = r_pool + scbp_pkg::HELD_W'(buf_len);
                end
            end
            default: begin
                n_status = scbp_pkg::ST_ZERO_SIZE;
            end
        endcase
    end

    assign store_req.pop    = s_acc && do_pop;
    assign store_req.push   = s_acc && do_push;
    assign store_req.cls    = scbp_pkg::CLS_W'(cls_shift - lo);
    assign store_req.handle = buf_handle[scbp_pkg::STORED_W-1:0];

    scbp_free_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (store_req),
        .o_count     (cls_count),
        .o_rd_handle (rd_handle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_shift <= scbp_pkg::MIN_SHIFT_RST;
            r_max_shift <= scbp_pkg::MAX_SHIFT_RST;
            r_max_bytes <= scbp_pkg::MAX_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                scbp_pkg::REG_MIN_SHIFT: r_min_shift <= i_cfg_wdata[scbp_pkg::SHIFT_W-1:0];
                scbp_pkg::REG_MAX_SHIFT: r_max_shift <= i_cfg_wdata[scbp_pkg::SHIFT_W-1:0];
                scbp_pkg::REG_MAX_BYTES: r_max_bytes <= i_cfg_wdata[scbp_pkg::MAXB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pool  <= '0;
        end else begin
            if (s_acc) begin
                r_valid <= 1'b1;
                r_pool  <= n_pool;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_status <= n_status;
            r_glen   <= n_glen;
            r_held   <= n_pool;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'b0, r_held, r_glen,
                            (r_status == scbp_pkg::ST_TAKEN) ?
                            scbp_pkg::HANDLE_W'(rd_handle) : scbp_pkg::HANDLE_W'(0)};

    a_pooled_adds_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_status == scbp_pkg::ST_POOLED) |=>
        r_pool == $past(r_pool) + scbp_pkg::HELD_W'($past(buf_len)))
        else $error("pooled release did not add its length to held bytes");

    a_taken_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == scbp_pkg::ST_TAKEN) |-> r_glen != '0)
        else $error("taken result with zero granted length");

    a_over_limit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == scbp_pkg::ST_OVER_LIMIT) |->
        r_held >= {1'b0, r_max_bytes})
        else $error("over-limit result while held bytes are below the limit");

endmodule

`default_nettype wire

[sim/scbp_result_checker.sv]
module scbp_result_checker
    import scbp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                    s_axis_tvalid,
    input  wire logic                    s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                    s_axis_tuser,
    input  wire logic                    m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [STATUS_W-1:0]     m_axis_tuser,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   len;
        logic [HELD_W-1:0]   held;
    } t_pool_result;

    // own copy of the pool: per-class ring of handles plus the held-byte count
    logic [HANDLE_W-1:0] slot_mem [NUM_CLASSES][CLASS_DEPTH];
    int                  slot_head  [NUM_CLASSES];
    int                  slot_tail  [NUM_CLASSES];
    int                  slot_count [NUM_CLASSES];
    logic [HELD_W-1:0]   held_bytes;

    logic [SHIFT_W-1:0]  cfg_min_shift;
    logic [SHIFT_W-1:0]  cfg_max_shift;
    logic [MAXB_W-1:0]   cfg_byte_limit;

    t_pool_result        pending_results [$];
    int                  fail_cnt;
    int                  checked_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fail_cnt     = 0;
        checked_cnt  = 0;
    end

    function automatic int round_up_shift(input longint unsigned v);
        int s;
        s = 0;
        while (s < 26 && (64'd1 << s) < v) begin
            s++;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got_v,
                                   input longint unsigned want_v);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 checked_cnt, what, got_v, want_v);
        fail_cnt++;
    endtask

    task automatic clear_pool();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            slot_head[c]  = 0;
            slot_tail[c]  = 0;
            slot_count[c] = 0;
        end
        held_bytes     = '0;
        cfg_min_shift  = MIN_SHIFT_RST;
        cfg_max_shift  = MAX_SHIFT_RST;
        cfg_byte_limit = MAX_BYTES_RST;
        pending_results.delete();
    endtask

    task automatic predict_pool_op(input logic op, input logic [SIZE_W-1:0] size,
                                   input logic [HANDLE_W-1:0] hdl,
                                   input logic [SIZE_W-1:0] len);
        t_pool_result    r;
        int              lo;
        int              hi;
        int              s;
        int              c;
        bit              any_class;
        longint unsigned lv;
        longint unsigned glen;
        lo = (cfg_min_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : int'(cfg_min_shift);
        hi = (cfg_max_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : int'(cfg_max_shift);
        if (hi > lo + NUM_CLASSES - 1) begin
            hi = lo + NUM_CLASSES - 1;
        end
        any_class = (lo <= hi);
        lv = longint'(len);
        r = '0;
        if (op == OP_ALLOC) begin
            if (size == '0) begin
                r.status = ST_ZERO_SIZE;
            end else begin
                s = round_up_shift(longint'(size));
                glen = (s <= SHIFT_LIMIT) ? (64'd1 << s) : 64'd0;
                r.len = SIZE_W'(glen);
                if (!any_class || s < lo || s > hi) begin
                    r.status = ST_OUT_RANGE;
                end else begin
                    c = s - lo;
                    if (slot_count[c] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.handle = slot_mem[c][slot_head[c]];
                        slot_head[c] = (slot_head[c] + 1) % CLASS_DEPTH;
                        slot_count[c]--;
                        // a take larger than the count (after a config change) empties it
                        if (longint'(held_bytes) >= glen) begin
                            held_bytes = held_bytes - HELD_W'(glen);
                        end else begin
                            held_bytes = '0;
                        end
                        r.status = ST_TAKEN;
                    end
                end
            end
        end else begin
            if (!any_class || lv < (64'd1 << lo) || lv > (64'd1 << hi)) begin
                r.status = ST_OUT_RANGE;
            end else if ((lv & (lv - 64'd1)) != 0) begin
                r.status = ST_BAD_LEN;
            end else if (longint'(held_bytes) >= longint'(cfg_byte_limit)) begin
                r.status = ST_OVER_LIMIT;
            end else begin
                c = round_up_shift(lv) - lo;
                if (slot_count[c] >= CLASS_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_mem[c][slot_tail[c]] = hdl;
                    slot_tail[c] = (slot_tail[c] + 1) % CLASS_DEPTH;
                    slot_count[c]++;
                    held_bytes = held_bytes + HELD_W'(lv);
                    r.status = ST_POOLED;
                end
            end
        end
        r.held = held_bytes;
        pending_results.insert(pending_results.size(), r);
    endtask

    always @(posedge i_clk) begin : watch
        t_pool_result got;
        t_pool_result want;
        if (!i_rst_n) begin
            clear_pool();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MIN_SHIFT: cfg_min_shift  = i_cfg_wdata[SHIFT_W-1:0];
                    REG_MAX_SHIFT: cfg_max_shift  = i_cfg_wdata[SHIFT_W-1:0];
                    REG_MAX_BYTES: cfg_byte_limit = i_cfg_wdata[MAXB_W-1:0];
                    default: ;
                endcase
            end
            // predict first so a same-edge result still finds its expectation
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pool_op(s_axis_tuser, s_axis_tdata[24:0], s_axis_tdata[72:25],
                                s_axis_tdata[97:73]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.handle = m_axis_tdata[47:0];
                got.len    = m_axis_tdata[72:48];
                got.held   = m_axis_tdata[105:73];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding, status",
                                    got.status, 0);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.handle !== want.handle)
                        report_mismatch("granted_handle", got.handle, want.handle);
                    if (got.len !== want.len)
                        report_mismatch("granted_len", got.len, want.len);
                    if (got.held !== want.held)
                        report_mismatch("held_bytes", got.held, want.held);
                    checked_cnt++;
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

[sim/tb_top.sv]
module tb_top;
    import scbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    int fail_count;
    int pending_count;
    int checked_count;
    int n_sent = 0;
    int n_writes = 0;
    bit calm = 1'b0;

    size_class_buffer_pool_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scbp_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side stalls at random except during the calm stretch
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 35);
    end

    initial begin
        #5000000;
        $display("size_class_buffer_pool_unit test failed");
        $finish;
    end

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [SIZE_W-1:0] noise_size();
        case ($urandom_range(4))
            0: return SIZE_W'($urandom);
            1: return SIZE_W'($urandom_range(2100));
            2: return SIZE_W'(32'h100_0000 - 1 + $urandom_range(2));
            3: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                                input logic [HANDLE_W-1:0] hdl,
                                input logic [SIZE_W-1:0] len);
        while (!calm && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, len, hdl, size};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_writes++;
    endtask

    // mostly well-formed pool traffic over shifts lo_s..hi_s, the rest noise
    task automatic random_mix(input int n, input int lo_s, input int hi_s,
                              input int release_pct);
        int s;
        logic [SIZE_W-1:0] size;
        for (int k = 0; k < n; k++) begin
            s = $urandom_range(hi_s, lo_s);
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(99) < release_pct) begin
                    send_request(OP_RELEASE, noise_size(), rand_handle(),
                                 SIZE_W'(1) << s);
                end else begin
                    if (s == 0 || $urandom_range(1) == 0)
                        size = SIZE_W'(1) << s;
                    else
                        size = (SIZE_W'(1) << (s - 1)) +
                               SIZE_W'($urandom_range(32'(1) << (s - 1), 1));
                    send_request(OP_ALLOC, size, rand_handle(), noise_size());
                end
            end else begin
                send_request(1'($urandom), noise_size(), rand_handle(), noise_size());
            end
        end
    endtask

    // overfill one class, then empty it again
    task automatic fill_and_drain(input int s, input int n);
        for (int k = 0; k < n; k++)
            send_request(OP_RELEASE, noise_size(), rand_handle(), SIZE_W'(1) << s);
        for (int k = 0; k < n; k++)
            send_request(OP_ALLOC, SIZE_W'(1) << s, rand_handle(), noise_size());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bounds 32..1024: edges of size, length and handle
        send_request(OP_ALLOC,   25'd0,         48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd1,         48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd31,        48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd32,        48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd1025,      48'd0,  25'd0);
        send_request(OP_ALLOC,   25'h100_0000,  48'd0,  25'd0);
        send_request(OP_ALLOC,   25'h100_0001,  48'd0,  25'd0);
        send_request(OP_ALLOC,   '1,            48'd0,  25'd0);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd0);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd16);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd48);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd2048);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), '1);
        send_request(OP_RELEASE, 25'd0,         '1,     25'd32);
        send_request(OP_RELEASE, 25'd0,         48'd0,  25'd32);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd1024);
        send_request(OP_RELEASE, 25'd0,         rand_handle(), 25'd768);
        send_request(OP_ALLOC,   25'd17,        48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd32,        48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd32,        48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd600,       48'd0,  25'd0);
        send_request(OP_ALLOC,   25'd1024,      48'd0,  25'd0);
        send_request(OP_RELEASE, '1,            rand_handle(), 25'd64);
        send_request(OP_ALLOC,   25'd64,        '1,     '1);
        random_mix(300, 4, 11, 50);

        // widest bounds: sixteen classes from 1 byte, no practical byte limit
        write_reg(REG_MIN_SHIFT, 32'd0);
        write_reg(REG_MAX_SHIFT, 32'd24);
        write_reg(REG_MAX_BYTES, 32'hFFFF_FFFF);
        fill_and_drain(0, 70);
        random_mix(250, 0, 17, 50);

        // shift values above the limit saturate to a single 16 MiB class
        write_reg(REG_MIN_SHIFT, {27'($urandom), 5'd24});
        write_reg(REG_MAX_SHIFT, {27'($urandom), 5'd31});
        write_reg(REG_MAX_BYTES, 32'h8000_0000);
        fill_and_drain(24, 70);
        random_mix(150, 22, 24, 50);

        // minimum above maximum: nothing is poolable
        write_reg(REG_MIN_SHIFT, 32'd12);
        write_reg(REG_MAX_SHIFT, 32'd3);
        random_mix(100, 0, 24, 50);

        // zero byte limit, handles from earlier settings still queued
        write_reg(REG_MIN_SHIFT, 32'd4);
        write_reg(REG_MAX_SHIFT, 32'd9);
        write_reg(REG_MAX_BYTES, 32'd0);
        random_mix(100, 3, 10, 70);

        // small limit so releases soon go over it
        write_reg(REG_MIN_SHIFT, 32'd6);
        write_reg(REG_MAX_SHIFT, 32'd8);
        write_reg(REG_MAX_BYTES, 32'd300);
        random_mix(200, 5, 9, 75);

        // back-to-back stretch with no stalls on either side
        write_reg(REG_MIN_SHIFT, 32'd0);
        write_reg(REG_MAX_SHIFT, 32'd5);
        write_reg(REG_MAX_BYTES, 32'($urandom_range(4000)));
        calm <= 1'b1;
        random_mix(250, 0, 6, 50);
        calm <= 1'b0;

        write_reg(REG_MIN_SHIFT, 32'(MIN_SHIFT_RST));
        write_reg(REG_MAX_SHIFT, 32'(MAX_SHIFT_RST));
        write_reg(REG_MAX_BYTES, 32'(MAX_BYTES_RST));
        random_mix(50, 4, 11, 50);

        wait_idle();
        $display("summary: %0d requests over %0d register writes (shifts 0..31, limit 0..max)",
                 n_sent, n_writes);
        $display("summary: %0d results checked, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0) begin
            $display("size_class_buffer_pool_unit test passed");
        end else begin
            $display("size_class_buffer_pool_unit test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/scbp_pkg.sv
rtl/scbp_free_store.sv
rtl/size_class_buffer_pool_unit.sv
sim/scbp_result_checker.sv
sim/tb_top.sv
